// ===== src/rltt_pkg.sv =====
// rltt_pkg: shared types, sizes and operation codes for the lru tag table
// depends on nothing; imported by every module of the block
`default_nettype none

package rltt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int ADDR_BITS = 32;
    localparam int REG_W     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef logic [REG_W-1:0]     t_reg_idx;
    typedef logic [ADDR_BITS-1:0] t_tag;

    typedef enum logic [2:0] {
        OP_LOOKUP   = 3'd0,
        OP_TAKE_LRU = 3'd1,
        OP_DROP     = 3'd2,
        OP_PROMOTE  = 3'd3,
        OP_BIND     = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] addr;
        logic        reorder;
        logic [2:0]  reg_sel;
    } t_in;

    typedef struct packed {
        logic [2:0] reg_num;
        logic       hit;
        logic [2:0] position;
        logic       error;
    } t_out;

    typedef struct packed {
        logic load_req;
        logic exec;
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

// ===== src/rltt_ctrl.sv =====
// rltt_ctrl: request sequencer and output handshake for the lru tag table
// depends on rltt_pkg; drives the command struct of rltt_dp
`default_nettype none

module rltt_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output rltt_pkg::t_cmd   o_cmd
);
    import rltt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.load_req = 1'b0;
        o_cmd.exec     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.exec | (r_out_valid & ~i_out_ready);
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("executed request produced no result");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.exec)
        else $error("pending result overwritten");
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !o_in_ready)
        else $error("request accepted while another executes");
`endif

endmodule

`default_nettype wire

// ===== src/rltt_dp.sv =====
// rltt_dp: tag registers, valid bits, recency order, match logic, result register
// depends on rltt_pkg; sequenced by rltt_ctrl through the command struct
`default_nettype none

module rltt_dp (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  rltt_pkg::t_cmd   i_cmd,
    input  rltt_pkg::t_in    i_in_req,
    output rltt_pkg::t_out   o_out_res
);
    import rltt_pkg::*;

    t_in      r_req;
    t_out     r_res, n_res;
    t_tag     r_tag   [NUM_REGS];
    logic     r_valid [NUM_REGS];
    t_reg_idx r_order [NUM_REGS];
    t_reg_idx n_order [NUM_REGS];
    logic     n_valid [NUM_REGS];

    t_tag              w_addr;
    logic [NUM_REGS-1:0] w_reg_match;
    logic [NUM_REGS-1:0] w_slot_match;
    logic              w_found;
    t_reg_idx          w_slot;
    t_reg_idx          w_sel;
    logic              w_bind;

    assign w_addr = t_tag'(r_req.addr);
    assign w_sel  = t_reg_idx'(r_req.reg_sel);
    assign w_bind = i_cmd.exec && (r_req.operation == OP_BIND)
                    && (32'(r_req.reg_sel) < 32'(NUM_REGS));

    always_comb begin
        for (int k = 0; k < NUM_REGS; k++) begin
            w_reg_match[k] = r_valid[k] && (r_tag[k] == w_addr);
        end
        for (int s = 0; s < NUM_REGS; s++) begin
            w_slot_match[s] = w_reg_match[r_order[s]];
        end
    end

    // first match from the least-recent end
    always_comb begin
        w_found = 1'b0;
        w_slot  = '0;
        for (int s = NUM_REGS - 1; s >= 0; s--) begin
            if (w_slot_match[s]) begin
                w_found = 1'b1;
                w_slot  = t_reg_idx'(s);
            end
        end
    end

    always_comb begin
        logic     to_mru;
        logic     to_lru;
        t_reg_idx mv_slot;
        t_reg_idx mv_reg;
        to_mru  = 1'b0;
        to_lru  = 1'b0;
        mv_slot = '0;
        n_res   = '0;
        for (int k = 0; k < NUM_REGS; k++) begin
            n_valid[k] = r_valid[k];
        end
        case (r_req.operation)
            OP_LOOKUP: begin
                if (w_found) begin
                    n_res.reg_num  = 3'(r_order[w_slot]);
                    n_res.hit      = 1'b1;
                    n_res.position = 3'(w_slot);
                    mv_slot        = w_slot;
                end else begin
                    n_res.reg_num = 3'(r_order[0]);
                end
                to_mru = r_req.reorder;
            end
            OP_TAKE_LRU: begin
                n_res.reg_num = 3'(r_order[0]);
                to_mru        = r_req.reorder;
            end
            OP_DROP: begin
                if (w_found) begin
                    n_res.reg_num  = 3'(r_order[w_slot]);
                    n_res.hit      = 1'b1;
                    n_res.position = 3'(w_slot);
                    mv_slot        = w_slot;
                    to_lru         = 1'b1;
                    n_valid[r_order[w_slot]] = 1'b0;
                end
            end
            OP_PROMOTE: begin
                if (w_found) begin
                    n_res.reg_num  = 3'(r_order[w_slot]);
                    n_res.hit      = 1'b1;
                    n_res.position = 3'(w_slot);
                    mv_slot        = w_slot;
                    to_mru         = 1'b1;
                end else begin
                    n_res.error = 1'b1;
                end
            end
            OP_BIND: begin
                if (32'(r_req.reg_sel) < 32'(NUM_REGS)) begin
                    n_res.reg_num = r_req.reg_sel;
                    n_valid[w_sel] = 1'b1;
                end
            end
            default: n_res = '0;
        endcase

        mv_reg = r_order[mv_slot];
        for (int s = 0; s < NUM_REGS; s++) begin
            n_order[s] = r_order[s];
        end
        if (to_mru) begin
            for (int s = 0; s < NUM_REGS - 1; s++) begin
                if (t_reg_idx'(s) >= mv_slot) begin
                    n_order[s] = r_order[s + 1];
                end
            end
            n_order[NUM_REGS - 1] = mv_reg;
        end else if (to_lru) begin
            for (int s = 1; s < NUM_REGS; s++) begin
                if (t_reg_idx'(s) <= mv_slot) begin
                    n_order[s] = r_order[s - 1];
                end
            end
            n_order[0] = mv_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_req;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
        if (w_bind) begin
            r_tag[w_sel] <= w_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_valid[k] <= 1'b0;
                r_order[k] <= t_reg_idx'(k);
            end
        end else if (i_cmd.exec) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_valid[k] <= n_valid[k];
                r_order[k] <= n_order[k];
            end
        end
    end

    assign o_out_res = r_res;

endmodule

`default_nettype wire

// ===== src/register_lru_tag_table_top.sv =====
// register_lru_tag_table_top: recency-ordered tag register table, top level
// depends on rltt_pkg, rltt_ctrl and rltt_dp
//
//   channel   direction  handshake                   payload
//   request   in         i_in_valid / o_in_ready     i_in_req   (t_in)
//   result    out        o_out_valid / i_out_ready   o_out_res  (t_out)
//
// each request is captured in the idle state; the execute state does the parallel tag compare
// and the single shift of the order registers, which loads the result register
// a result held by a stalled consumer holds the execute cycle, not the capture
// synchronous active-low reset: order is identity, all tags invalid
`default_nettype none

module register_lru_tag_table_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  rltt_pkg::t_in    i_in_req,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output rltt_pkg::t_out   o_out_res
);
    import rltt_pkg::*;

    t_cmd w_cmd;

    rltt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    rltt_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_in_req  (i_in_req),
        .o_out_res (o_out_res)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for register_lru_tag_table_top, with randomized request traffic
// a scoreboard class predicts each result from its own copy of the recency order and the tags
// depends on rltt_pkg and register_lru_tag_table_top

module tb_top;

    import rltt_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI  = 3'd7;
    localparam int MAX_GAP      = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_SIZE    = 16;

    class lru_order_scoreboard;
        t_reg_idx order[NUM_REGS];
        t_tag     tags[NUM_REGS];
        bit       valid_bits[NUM_REGS];
        t_out     lookup_outcomes[$];
        int       fails;

        function new();
            for (int k = 0; k < NUM_REGS; k++) begin
                order[k]      = t_reg_idx'(k);
                tags[k]       = '0;
                valid_bits[k] = 1'b0;
            end
            fails = 0;
        endfunction

        // least recent valid match wins
        function int find_slot(t_tag a);
            for (int s = 0; s < NUM_REGS; s++) begin
                if (valid_bits[order[s]] && tags[order[s]] == a) begin
                    return s;
                end
            end
            return -1;
        endfunction

        function void to_mru(int slot);
            t_reg_idx r;
            r = order[slot];
            for (int s = slot; s < NUM_REGS - 1; s++) begin
                order[s] = order[s + 1];
            end
            order[NUM_REGS - 1] = r;
        endfunction

        function void to_lru(int slot);
            t_reg_idx r;
            r = order[slot];
            for (int s = slot; s > 0; s--) begin
                order[s] = order[s - 1];
            end
            order[0] = r;
        endfunction

        function t_out predict_outcome(t_in r);
            t_out o;
            t_tag a;
            int   slot;
            o    = '0;
            a    = t_tag'(r.addr);
            slot = -1;
            case (r.operation)
                OP_LOOKUP: begin
                    slot = find_slot(a);
                    if (slot >= 0) begin
                        o.reg_num  = 3'(order[slot]);
                        o.hit      = 1'b1;
                        o.position = 3'(slot);
                        if (r.reorder) to_mru(slot);
                    end else begin
                        o.reg_num = 3'(order[0]);
                        if (r.reorder) to_mru(0);
                    end
                end
                OP_TAKE_LRU: begin
                    o.reg_num = 3'(order[0]);
                    if (r.reorder) to_mru(0);
                end
                OP_DROP: begin
                    slot = find_slot(a);
                    if (slot >= 0) begin
                        o.reg_num  = 3'(order[slot]);
                        o.hit      = 1'b1;
                        o.position = 3'(slot);
                        valid_bits[order[slot]] = 1'b0;
                        to_lru(slot);
                    end
                end
                OP_PROMOTE: begin
                    slot = find_slot(a);
                    if (slot >= 0) begin
                        o.reg_num  = 3'(order[slot]);
                        o.hit      = 1'b1;
                        o.position = 3'(slot);
                        to_mru(slot);
                    end else begin
                        o.error = 1'b1;
                    end
                end
                OP_BIND: begin
                    if (int'(r.reg_sel) < NUM_REGS) begin
                        tags[r.reg_sel]       = a;
                        valid_bits[r.reg_sel] = 1'b1;
                        o.reg_num             = r.reg_sel;
                    end
                end
                default: ;
            endcase
            return o;
        endfunction

        function void note_request(t_in r);
            lookup_outcomes.push_back(predict_outcome(r));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (lookup_outcomes.size() == 0) begin
                $error("result with no request pending: %h", got);
                fails++;
                return;
            end
            want = lookup_outcomes.pop_front();
            if (got.reg_num !== want.reg_num) begin
                $error("reg_num: expected %0d, actual %0d", want.reg_num, got.reg_num);
                fails++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                fails++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                fails++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0d, actual %0d", want.error, got.error);
                fails++;
            end
        endfunction

        function int pending();
            return lookup_outcomes.size();
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_req    = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_res;

    bit burst_mode   = 1'b0;
    bit hold_off_req = 1'b0;
    int cycle_count  = 0;

    lru_order_scoreboard sb;

    register_lru_tag_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("register_lru_tag_table_top verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_request(i_in_req);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_res);
        end
    end

    task automatic send_request(t_in r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_fields(logic [2:0] op, logic [31:0] addr, logic reorder,
                               logic [2:0] sel);
        t_in r;
        r.operation = op;
        r.addr      = addr;
        r.reorder   = reorder;
        r.reg_sel   = sel;
        send_request(r);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [31:0] addr_pool[POOL_SIZE];
        t_in r;
        int  pick;
        sb = new();
        for (int k = 0; k < POOL_SIZE; k++) begin
            addr_pool[k] = $urandom;
        end
        addr_pool[0] = '0;
        addr_pool[1] = '1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: zero tags are not valid
        send_fields(OP_LOOKUP,   32'h0000_0000, 1'b0, 3'd0);
        send_fields(OP_TAKE_LRU, 32'h0000_0000, 1'b1, 3'd7);
        send_fields(OP_PROMOTE,  32'hFFFF_FFFF, 1'b0, 3'd0);
        send_fields(OP_DROP,     32'hFFFF_FFFF, 1'b1, 3'd0);
        send_fields(OP_BIND,     32'h0000_0000, 1'b0, 3'd0);
        send_fields(OP_BIND,     32'hFFFF_FFFF, 1'b1, 3'd7);
        // duplicate tags in two registers
        send_fields(OP_BIND,     32'h5555_AAAA, 1'b0, 3'd3);
        send_fields(OP_BIND,     32'h5555_AAAA, 1'b0, 3'd5);
        send_fields(OP_LOOKUP,   32'h5555_AAAA, 1'b1, 3'd2);
        send_fields(OP_LOOKUP,   32'hFFFF_FFFF, 1'b0, 3'd5);
        send_fields(OP_PROMOTE,  32'h0000_0000, 1'b1, 3'd1);
        send_fields(OP_DROP,     32'h5555_AAAA, 1'b0, 3'd6);
        send_fields(OP_LOOKUP,   32'h5555_AAAA, 1'b1, 3'd4);
        send_fields(OP_LOOKUP,   32'hAAAA_5555, 1'b1, 3'd0);
        send_fields(OP_TAKE_LRU, 32'hAAAA_5555, 1'b0, 3'd0);
        // unused operation codes
        send_fields(OP_UNUSED_LO,  $urandom,     1'b1, 3'd7);
        send_fields(OP_UNUSED_MID, $urandom,     1'b0, 3'd2);
        send_fields(OP_UNUSED_HI,  32'hFFFF_FFFF, 1'b1, 3'd5);
        // dropped register keeps its tag but no longer matches
        send_fields(OP_BIND,     32'h0000_0001, 1'b0, 3'd2);
        send_fields(OP_DROP,     32'h0000_0001, 1'b0, 3'd2);
        send_fields(OP_LOOKUP,   32'h0000_0001, 1'b0, 3'd2);
        send_fields(OP_PROMOTE,  32'h0000_0001, 1'b0, 3'd2);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            burst_mode = (n % 150) >= 110;
            if (n == 300) hold_off_req = 1'b1;
            if (n == 600) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)      r.operation = OP_LOOKUP;
            else if (pick < 45) r.operation = OP_TAKE_LRU;
            else if (pick < 57) r.operation = OP_DROP;
            else if (pick < 72) r.operation = OP_PROMOTE;
            else if (pick < 95) r.operation = OP_BIND;
            else                r.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            if ($urandom_range(0, 99) < 85) r.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            else                            r.addr = $urandom;
            r.reorder = 1'($urandom_range(0, 1));
            r.reg_sel = 3'($urandom_range(0, 7));
            send_request(r);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("results missing: %0d", sb.pending());
            sb.fails++;
        end
        if (sb.fails == 0) begin
            $display("register_lru_tag_table_top verification clean");
        end else begin
            $display("register_lru_tag_table_top verification failed");
        end
        $finish;
    end

endmodule
